@@ sv/ols_pkg.sv @@
// Shared constants, codes and types for the ordered list store.
`default_nettype none

package ols_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int GRP_SIZE = 8;
   localparam int GRP_NUM  = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

   localparam int MODE_W = 3;
   localparam int DATA_W = 32;
   localparam int POS_W  = 16;
   localparam int STAT_W = 2;
   localparam int ECNT_W = 7;

   localparam logic [MODE_W-1:0] MODE_INS_FRONT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_INS_REAR  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_INS_POS   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DEL_FRONT = 3'd3;
   localparam logic [MODE_W-1:0] MODE_DEL_REAR  = 3'd4;

   localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

   typedef logic signed [DATA_W-1:0] word_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_POP
   } cell_op_type;

   // Broadcast to every cell in the chain.
   typedef struct packed {
      cell_op_type      op;
      logic [IDX_W-1:0] ins_idx;
      logic [IDX_W-1:0] rear_idx;
      word_type         value;
   } cell_cmd_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      word_type          removed_value;
      logic [ECNT_W-1:0] element_count;
   } result_type;

endpackage

`default_nettype wire

@@ sv/ols_if.sv @@
// Request and response channel interfaces for the ordered list store.
`default_nettype none

interface ols_req_if;
   logic                                  valid;
   logic                                  ready;
   logic        [ols_pkg::MODE_W-1:0]     mode;
   logic signed [ols_pkg::DATA_W-1:0]     value;
   logic        [ols_pkg::POS_W-1:0]      position;

   modport source (output valid, output mode, output value, output position, input ready);
   modport sink   (input valid, input mode, input value, input position, output ready);
endinterface

interface ols_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic        [ols_pkg::STAT_W-1:0]     status;
   logic signed [ols_pkg::DATA_W-1:0]     removed_value;
   logic        [ols_pkg::ECNT_W-1:0]     element_count;

   modport source (output valid, output status, output removed_value, output element_count,
                   input ready);
   modport sink   (input valid, input status, input removed_value, input element_count,
                   output ready);
endinterface

`default_nettype wire

@@ sv/ols_cell.sv @@
// One storage cell of the list chain: holds one element, shifts with its neighbors.
`default_nettype none

module ols_cell (
   input  logic                        clock,
   input  ols_pkg::cell_cmd_type       cmd,
   input  logic [ols_pkg::IDX_W-1:0]   cell_index,
   input  ols_pkg::word_type           left_data,
   input  ols_pkg::word_type           right_data,
   output ols_pkg::word_type           data,
   output ols_pkg::word_type           rear_data
);

   ols_pkg::word_type data_ff;
   ols_pkg::word_type data_in;

   always_comb begin
      data_in = data_ff;
      unique case (cmd.op)
         ols_pkg::OP_HOLD: begin
            data_in = data_ff;
         end
         ols_pkg::OP_INSERT: begin
            // take the new value at the slot, move everything behind it one place back
            if (cell_index == cmd.ins_idx) begin
               data_in = cmd.value;
            end else if (cell_index > cmd.ins_idx) begin
               data_in = left_data;
            end
         end
         ols_pkg::OP_POP: begin
            data_in = right_data;
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data      = data_ff;
   assign rear_data = (cell_index == cmd.rear_idx) ? data_ff : '0;

endmodule

`default_nettype wire

@@ sv/ols_rear_tree.sv @@
// Two-level registered OR tree that collects the rear element from the cell chain.
`default_nettype none

module ols_rear_tree (
   input  logic              clock,
   input  ols_pkg::word_type tap [ols_pkg::CAPACITY],
   output ols_pkg::word_type rear_value
);

   ols_pkg::word_type grp_ff [ols_pkg::GRP_NUM];
   ols_pkg::word_type grp_in [ols_pkg::GRP_NUM];
   ols_pkg::word_type rear_ff;
   ols_pkg::word_type rear_in;

   // only the rear cell drives a nonzero tap, so OR acts as a one-hot select
   always_comb begin
      for (int g = 0; g < ols_pkg::GRP_NUM; g++) begin
         grp_in[g] = '0;
         for (int k = 0; k < ols_pkg::GRP_SIZE; k++) begin
            if (g * ols_pkg::GRP_SIZE + k < ols_pkg::CAPACITY) begin
               grp_in[g] = grp_in[g] | tap[g * ols_pkg::GRP_SIZE + k];
            end
         end
      end
   end

   always_comb begin
      rear_in = '0;
      for (int g = 0; g < ols_pkg::GRP_NUM; g++) begin
         rear_in = rear_in | grp_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      grp_ff  <= grp_in;
      rear_ff <= rear_in;
   end

   assign rear_value = rear_ff;

endmodule

`default_nettype wire

@@ sv/ordered_list_store_top.sv @@
// Top level of the ordered list store: cell chain, count, rear tree and result buffer.
//
//   channel   dir   handshake      payload
//   req_ch    in    valid/ready    mode, value, position
//   rsp_ch    out   valid/ready    status, removed_value, element_count
//
// After each accepted item the cell chain shifts in the accept cycle, then the
// two-stage rear OR tree (group registers, then rear register) presents the new rear element.
// Reset clears the count, the settle counter and the result buffer; cell
// contents are not cleared. A two-entry result buffer lets the next item
// enter while one result waits on rsp_ch; ready drops once both entries fill.
`default_nettype none

module ordered_list_store_top (
   input  logic            clock,
   input  logic            reset,
   ols_req_if.sink         req_ch,
   ols_rsp_if.source       rsp_ch
);

   localparam logic [1:0] SETTLE_CYCLES = 2'd2;

   logic [ols_pkg::CNT_W-1:0] count_ff;
   logic [ols_pkg::CNT_W-1:0] count_in;
   logic [1:0]                settle_ff;
   logic [1:0]                settle_in;

   ols_pkg::result_type head_ff, head_in, tail_ff, tail_in, res;
   logic                head_vld_ff, head_vld_in, tail_vld_ff, tail_vld_in;

   ols_pkg::cell_cmd_type cmd;
   ols_pkg::word_type     cell_data [ols_pkg::CAPACITY];
   ols_pkg::word_type     rear_tap  [ols_pkg::CAPACITY];
   ols_pkg::word_type     rear_value;

   logic                       accept, pop, push;
   logic                       is_ins, is_del, full, empty;
   logic [ols_pkg::POS_W-1:0]  pos_m1, pos_idx, ins_idx, count_pos;
   logic [31:0]                count_wide;

   assign req_ch.ready = (settle_ff == 2'd0) && !tail_vld_ff;
   assign accept       = req_ch.valid && req_ch.ready;

   assign is_ins = (req_ch.mode == ols_pkg::MODE_INS_FRONT) ||
                   (req_ch.mode == ols_pkg::MODE_INS_REAR)  ||
                   (req_ch.mode == ols_pkg::MODE_INS_POS);
   assign is_del = (req_ch.mode == ols_pkg::MODE_DEL_FRONT) ||
                   (req_ch.mode == ols_pkg::MODE_DEL_REAR);
   assign full   = (count_ff == ols_pkg::CNT_W'(ols_pkg::CAPACITY));
   assign empty  = (count_ff == '0);

   // clamp positional insert to the current length
   assign count_pos = ols_pkg::POS_W'(count_ff);
   assign pos_m1    = req_ch.position - ols_pkg::POS_W'(1);
   assign pos_idx   = (req_ch.position <= ols_pkg::POS_W'(1)) ? '0 :
                      ((pos_m1 > count_pos) ? count_pos : pos_m1);

   always_comb begin
      ins_idx = '0;
      if (req_ch.mode == ols_pkg::MODE_INS_REAR) begin
         ins_idx = count_pos;
      end else if (req_ch.mode == ols_pkg::MODE_INS_POS) begin
         ins_idx = pos_idx;
      end
   end

   always_comb begin
      cmd.op       = ols_pkg::OP_HOLD;
      cmd.ins_idx  = ins_idx[ols_pkg::IDX_W-1:0];
      cmd.rear_idx = ols_pkg::IDX_W'(count_ff - ols_pkg::CNT_W'(1));
      cmd.value    = req_ch.value;
      if (accept && is_ins && !full) begin
         cmd.op = ols_pkg::OP_INSERT;
      end else if (accept && (req_ch.mode == ols_pkg::MODE_DEL_FRONT) && !empty) begin
         cmd.op = ols_pkg::OP_POP;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (accept && is_ins && !full) begin
         count_in = count_ff + ols_pkg::CNT_W'(1);
      end else if (accept && is_del && !empty) begin
         count_in = count_ff - ols_pkg::CNT_W'(1);
      end
   end

   always_comb begin
      count_wide        = 32'(count_in);
      res.status        = ols_pkg::ST_DONE;
      res.removed_value = '0;
      res.element_count = count_wide[ols_pkg::ECNT_W-1:0];
      if (is_ins && full) begin
         res.status = ols_pkg::ST_FULL;
      end else if (is_del && empty) begin
         res.status = ols_pkg::ST_EMPTY;
      end else if (req_ch.mode == ols_pkg::MODE_DEL_FRONT) begin
         res.removed_value = cell_data[0];
      end else if (req_ch.mode == ols_pkg::MODE_DEL_REAR) begin
         res.removed_value = rear_value;
      end
   end

   genvar i;
   generate
      for (i = 0; i < ols_pkg::CAPACITY; i++) begin : g_cell
         ols_pkg::word_type left_d, right_d;
         if (i == 0) begin : g_first
            assign left_d = '0;
         end else begin : g_mid_l
            assign left_d = cell_data[i-1];
         end
         if (i == ols_pkg::CAPACITY - 1) begin : g_last
            assign right_d = '0;
         end else begin : g_mid_r
            assign right_d = cell_data[i+1];
         end
         ols_cell u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .cell_index (ols_pkg::IDX_W'(i)),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i]),
            .rear_data  (rear_tap[i])
         );
      end
   endgenerate

   ols_rear_tree u_rear_tree (
      .clock      (clock),
      .tap        (rear_tap),
      .rear_value (rear_value)
   );

   always_comb begin
      settle_in = settle_ff;
      if (accept) begin
         settle_in = SETTLE_CYCLES;
      end else if (settle_ff != 2'd0) begin
         settle_in = settle_ff - 2'd1;
      end
   end

   // two-entry result buffer
   assign push = accept;
   assign pop  = head_vld_ff && rsp_ch.ready;

   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      head_vld_in = head_vld_ff;
      tail_vld_in = tail_vld_ff;
      if (pop) begin
         head_in     = tail_vld_ff ? tail_ff : res;
         head_vld_in = tail_vld_ff || push;
         tail_vld_in = 1'b0;
      end else if (push) begin
         if (!head_vld_ff) begin
            head_in     = res;
            head_vld_in = 1'b1;
         end else begin
            tail_in     = res;
            tail_vld_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         settle_ff   <= 2'd0;
         head_vld_ff <= 1'b0;
         tail_vld_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         settle_ff   <= settle_in;
         head_vld_ff <= head_vld_in;
         tail_vld_ff <= tail_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign rsp_ch.valid         = head_vld_ff;
   assign rsp_ch.status        = head_ff.status;
   assign rsp_ch.removed_value = head_ff.removed_value;
   assign rsp_ch.element_count = head_ff.element_count;

endmodule

`default_nettype wire

@@ sv/ols_checker.sv @@
// Port-level assertions for the ordered list store and their bind to the top level.
`default_nettype none

module ols_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic        [ols_pkg::STAT_W-1:0]  rsp_status,
   input logic signed [ols_pkg::DATA_W-1:0]  rsp_removed_value,
   input logic        [ols_pkg::ECNT_W-1:0]  rsp_element_count
);

   // a full report means nothing moved and the list stands at capacity
   a_full_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ols_pkg::ST_FULL) |->
         (rsp_removed_value == '0) &&
         (rsp_element_count == ols_pkg::ECNT_W'(ols_pkg::CAPACITY)))
      else $error("full status with bad removed value or count");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ols_pkg::ST_EMPTY) |->
         (rsp_removed_value == '0) && (rsp_element_count == '0))
      else $error("empty status with bad removed value or count");

   // the chain needs time to settle after each item
   a_settle_gap: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted before the chain settled");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_status) && $stable(rsp_removed_value) &&
         $stable(rsp_element_count))
      else $error("stalled result changed");

endmodule

bind ordered_list_store_top ols_checker u_ols_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_status        (rsp_ch.status),
   .rsp_removed_value (rsp_ch.removed_value),
   .rsp_element_count (rsp_ch.element_count)
);

`default_nettype wire

@@ dv/ordered_list_store_top_test.sv @@
// Self-checking testbench for the ordered list store: directed and random list operations against a queue model.
`timescale 1ns / 100ps

module ordered_list_store_top_test;

   localparam logic [ols_pkg::MODE_W-1:0] MODE_SPARE_FIRST =
      ols_pkg::MODE_W'(ols_pkg::MODE_DEL_REAR + 1);
   localparam logic [ols_pkg::MODE_W-1:0] MODE_SPARE_LAST  = '1;
   localparam ols_pkg::word_type WORD_MIN = {1'b1, {(ols_pkg::DATA_W-1){1'b0}}};
   localparam ols_pkg::word_type WORD_MAX = {1'b0, {(ols_pkg::DATA_W-1){1'b1}}};
   localparam int                RANDOM_ITEMS     = 500;
   localparam int                IDLE_PERCENT     = 13;
   localparam int                STALL_LIMIT      = 1000;
   localparam int                DRAIN_CYCLES     = 12;
   localparam int                HOLD_CYCLES      = 80;

   typedef struct {
      logic [ols_pkg::MODE_W-1:0] mode;
      ols_pkg::word_type          value;
      logic [ols_pkg::POS_W-1:0]  position;
   } list_req_type;

   logic clock;
   logic reset;

   ols_req_if req_ch ();
   ols_rsp_if rsp_ch ();

   ordered_list_store_top i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   list_req_type        request_backlog[$];
   ols_pkg::result_type pending_results[$];
   ols_pkg::word_type   shadow_list[$];

   int gen_count;
   int items_accepted;
   int results_seen;
   int error_count;
   int stall_cycles;
   int hold_left;
   bit hold_done;
   int inserts_done;
   int deletes_done;
   int full_rejects;
   int empty_rejects;
   int spare_ops;
   int peak_count;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Apply one operation to the shadow list and return the result it should produce.
   function automatic ols_pkg::result_type apply_list_op(list_req_type r);
      ols_pkg::result_type res;
      int                  idx;
      res.status        = ols_pkg::ST_DONE;
      res.removed_value = '0;
      case (r.mode)
         ols_pkg::MODE_INS_FRONT, ols_pkg::MODE_INS_REAR, ols_pkg::MODE_INS_POS: begin
            if (shadow_list.size() >= ols_pkg::CAPACITY) begin
               res.status = ols_pkg::ST_FULL;
               full_rejects++;
            end else begin
               if (r.mode == ols_pkg::MODE_INS_FRONT) begin
                  idx = 0;
               end else if (r.mode == ols_pkg::MODE_INS_REAR) begin
                  idx = shadow_list.size();
               end else begin
                  idx = (r.position <= 1) ? 0 : int'(r.position) - 1;
                  if (idx > shadow_list.size()) idx = shadow_list.size();
               end
               shadow_list.insert(idx, r.value);
               inserts_done++;
            end
         end
         ols_pkg::MODE_DEL_FRONT, ols_pkg::MODE_DEL_REAR: begin
            if (shadow_list.size() == 0) begin
               res.status = ols_pkg::ST_EMPTY;
               empty_rejects++;
            end else begin
               if (r.mode == ols_pkg::MODE_DEL_FRONT) res.removed_value = shadow_list.pop_front();
               else res.removed_value = shadow_list.pop_back();
               deletes_done++;
            end
         end
         default: spare_ops++;
      endcase
      if (shadow_list.size() > peak_count) peak_count = shadow_list.size();
      res.element_count = ols_pkg::ECNT_W'(shadow_list.size());
      return res;
   endfunction

   // Queue one item and track the list length it leaves behind.
   task automatic add_item(logic [ols_pkg::MODE_W-1:0] mode, ols_pkg::word_type value,
                           logic [ols_pkg::POS_W-1:0] position);
      list_req_type r;
      r.mode     = mode;
      r.value    = value;
      r.position = position;
      request_backlog.push_back(r);
      case (mode)
         ols_pkg::MODE_INS_FRONT, ols_pkg::MODE_INS_REAR, ols_pkg::MODE_INS_POS:
            if (gen_count < ols_pkg::CAPACITY) gen_count++;
         ols_pkg::MODE_DEL_FRONT, ols_pkg::MODE_DEL_REAR: if (gen_count > 0) gen_count--;
         default: ;
      endcase
   endtask

   // Request driver: hold an offered item until it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            pending_results.push_back(apply_list_op(request_backlog.pop_front()));
            items_accepted++;
         end
         if (req_ch.valid && !req_ch.ready) begin
            // hold
         end else if (request_backlog.size() > 0 &&
                      ((items_accepted >= 260 && items_accepted < 340) ||
                       $urandom_range(0, 99) >= IDLE_PERCENT)) begin
            req_ch.valid    <= 1'b1;
            req_ch.mode     <= request_backlog[0].mode;
            req_ch.value    <= request_backlog[0].value;
            req_ch.position <= request_backlog[0].position;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Response ready, with one long hold-off to back the block up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (!hold_done && results_seen >= 60) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= (results_seen >= 380 && results_seen < 460) ||
                            ($urandom_range(0, 99) >= IDLE_PERCENT);
         end
      end
   end

   // Response monitor.
   always @(posedge clock) begin : check_rsp
      ols_pkg::result_type exp;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            $error("unexpected item: status %0d removed_value %0d element_count %0d",
                   rsp_ch.status, rsp_ch.removed_value, rsp_ch.element_count);
            error_count++;
         end else begin
            exp = pending_results.pop_front();
            if (rsp_ch.status !== exp.status) begin
               $error("status: expected %0d, actual %0d", exp.status, rsp_ch.status);
               error_count++;
            end
            if (rsp_ch.removed_value !== exp.removed_value) begin
               $error("removed_value: expected %0d, actual %0d",
                      exp.removed_value, rsp_ch.removed_value);
               error_count++;
            end
            if (rsp_ch.element_count !== exp.element_count) begin
               $error("element_count: expected %0d, actual %0d",
                      exp.element_count, rsp_ch.element_count);
               error_count++;
            end
         end
      end
   end

   // Watchdog: too long without any item moving on either side.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            stall_cycles <= 0;
         end else if (stall_cycles >= STALL_LIMIT) begin
            $error("no item moved for %0d cycles, %0d results outstanding",
                   stall_cycles, pending_results.size());
            $display("Simulation FAILED");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   initial begin : stimulus
      int                         phase;
      int                         seg_len;
      int                         ins_pct;
      int                         n_random;
      int                         pick;
      logic [ols_pkg::MODE_W-1:0] m;
      ols_pkg::word_type          v;
      logic [ols_pkg::POS_W-1:0]  p;

      clock           = 1'b0;
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.mode     = '0;
      req_ch.value    = '0;
      req_ch.position = '0;
      rsp_ch.ready    = 1'b0;

      // Directed: empty deletes, spare modes, extreme values and positions, then drain.
      add_item(ols_pkg::MODE_DEL_FRONT, 32'sd5, 16'd0);
      add_item(ols_pkg::MODE_DEL_REAR, WORD_MAX, 16'd0);
      for (int s = MODE_SPARE_FIRST; s <= MODE_SPARE_LAST; s++)
         add_item(ols_pkg::MODE_W'(s), WORD_MIN, '1);
      add_item(ols_pkg::MODE_INS_FRONT, WORD_MAX, 16'd0);
      add_item(ols_pkg::MODE_INS_REAR, WORD_MIN, 16'd0);
      add_item(ols_pkg::MODE_INS_POS, -32'sd1, 16'd0);
      add_item(ols_pkg::MODE_INS_POS, 32'sd0, 16'd1);
      add_item(ols_pkg::MODE_INS_POS, 32'sh12345678, '1);
      add_item(ols_pkg::MODE_INS_POS, 32'sh5a5a5a5a, 16'd2);
      add_item(ols_pkg::MODE_INS_POS, 32'sh0f0f0f0f, 16'd3);
      add_item(MODE_SPARE_LAST, WORD_MAX, 16'd2);
      add_item(ols_pkg::MODE_DEL_FRONT, '0, '1);
      add_item(ols_pkg::MODE_DEL_REAR, '0, '1);
      while (gen_count > 0)
         add_item((gen_count % 2) ? ols_pkg::MODE_DEL_FRONT : ols_pkg::MODE_DEL_REAR, '0, '0);
      add_item(ols_pkg::MODE_DEL_REAR, '0, '0);

      // Random: cycle through fill, mixed, drain and mixed phases so both full and
      // empty lists come up repeatedly.
      n_random = 0;
      phase    = 0;
      while (n_random < RANDOM_ITEMS) begin
         case (phase % 4)
            0: begin seg_len = $urandom_range(80, 130); ins_pct = 90; end
            2: begin seg_len = $urandom_range(80, 130); ins_pct = 10; end
            default: begin seg_len = $urandom_range(30, 60); ins_pct = 50; end
         endcase
         repeat (seg_len) begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
               m = ols_pkg::MODE_W'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
            else if ($urandom_range(0, 99) < ins_pct)
               m = ols_pkg::MODE_W'($urandom_range(ols_pkg::MODE_INS_FRONT,
                                                   ols_pkg::MODE_INS_POS));
            else m = ols_pkg::MODE_W'($urandom_range(ols_pkg::MODE_DEL_FRONT,
                                                     ols_pkg::MODE_DEL_REAR));
            case ($urandom_range(0, 9))
               0: v = WORD_MIN;
               1: v = WORD_MAX;
               2: v = '0;
               default: v = $urandom;
            endcase
            if ($urandom_range(0, 99) < 60)
               p = ols_pkg::POS_W'($urandom_range(0, gen_count + 2));
            else p = ols_pkg::POS_W'($urandom);
            add_item(m, v, p);
            n_random++;
         end
         phase++;
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (request_backlog.size() != 0 || pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d list operations: %0d inserts, %0d deletes, %0d unused-mode items.",
               items_accepted, inserts_done, deletes_done, spare_ops);
      $display("Rejected %0d inserts on a full list and %0d deletes on an empty one; peak %0d.",
               full_rejects, empty_rejects, peak_count);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

@@ sim.f @@
sv/ols_pkg.sv
sv/ols_if.sv
sv/ols_cell.sv
sv/ols_rear_tree.sv
sv/ordered_list_store_top.sv
sv/ols_checker.sv
dv/ordered_list_store_top_test.sv
